FILE: rtl/sitda_pkg.sv
// shared constants and helpers for the signed integer to decimal text converter
`timescale 1ns / 1ps

package sitda_pkg;

  // input and output field widths
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned LenWidth   = 4;

  // widest decimal string of a 32-bit magnitude, in digits
  localparam int unsigned MaxDigits = 10;

  // digit position index, enough for MaxDigits positions
  localparam int unsigned PosWidth = $clog2(MaxDigits);

  // comparisons run wider than the magnitude so nine times a power of ten fits
  localparam int unsigned CmpWidth = ValueWidth + 2;

  // ascii codes
  localparam logic [CharWidth-1:0] CharZero  = 8'd48;
  localparam logic [CharWidth-1:0] CharMinus = 8'd45;

  // largest digit value
  localparam int unsigned MaxDigit = 9;

  // sequencer states
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StSize = 3'b010,
    StEmit = 3'b100
  } state_e;

  // power of ten at a digit position
  function automatic logic [CmpWidth-1:0] pow10(input logic [PosWidth-1:0] k);
    logic [CmpWidth-1:0] p;
    p = '0;
    case (k)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/signed_int_to_decimal_ascii.sv
// signed 32-bit integer to decimal ascii text, one character per output beat
// an accepted value passes through the size state into the emit state, which then registers one
// character per cycle while the output is not stalled; the pace is set by the one digit per cycle
//   compare-and-subtract unit and the single output register
// the input is stalled while a value is being converted
// reset: asynchronous active low, returns to idle with no output beat pending
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii
  import sitda_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [ValueWidth-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [CharWidth-1:0]        character_o,
  output logic [LenWidth-1:0]         text_length_o,
  output logic                        is_last_o
);

  state_e                 state_q, state_d;
  logic [ValueWidth-1:0]  mag_q, mag_d;
  logic                   neg_q, neg_d;
  logic                   sign_pend_q, sign_pend_d;
  logic [PosWidth-1:0]    pos_q, pos_d;
  logic [LenWidth-1:0]    len_q, len_d;

  logic                   out_valid_q, out_valid_d;
  logic [CharWidth-1:0]   char_q, char_d;
  logic                   last_q, last_d;

  logic                   in_acc;
  logic                   out_free;
  logic [LenWidth-1:0]    ndig;
  logic [3:0]             digit;
  logic [CmpWidth-1:0]    sub_amt;
  logic [CmpWidth-1:0]    mag_ext;
  logic [CmpWidth-1:0]    rem;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign mag_ext    = {{(CmpWidth-ValueWidth){1'b0}}, mag_q};

  // digit count: one plus the number of powers of ten, from ten upward, not above the magnitude
  always_comb begin
    ndig = LenWidth'(1);
    for (int k = 1; k < MaxDigits; k++) begin
      if (mag_ext >= pow10(PosWidth'(k))) begin
        ndig = ndig + LenWidth'(1);
      end
    end
  end

  // compare-and-subtract unit: digit at the current position and the remainder
  always_comb begin
    digit   = '0;
    sub_amt = '0;
    for (int d = 1; d <= MaxDigit; d++) begin
      if (mag_ext >= pow10(pos_q) * CmpWidth'(d)) begin
        digit   = 4'(d);
        sub_amt = pow10(pos_q) * CmpWidth'(d);
      end
    end
    rem = mag_ext - sub_amt;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    sign_pend_d = sign_pend_q;
    pos_d       = pos_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          neg_d   = value_i[ValueWidth-1];
          mag_d   = value_i[ValueWidth-1] ? (ValueWidth'(0) - ValueWidth'(value_i))
                                          : ValueWidth'(value_i);
          state_d = StSize;
        end
      end
      StSize: begin
        len_d       = ndig + LenWidth'(neg_q);
        pos_d       = PosWidth'(ndig - LenWidth'(1));
        sign_pend_d = neg_q;
        state_d     = StEmit;
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (sign_pend_q) begin
            // minus sign leads, never the last character
            char_d      = CharMinus;
            last_d      = 1'b0;
            sign_pend_d = 1'b0;
          end else begin
            char_d = CharZero + CharWidth'(digit);
            last_d = (pos_q == '0);
            mag_d  = rem[ValueWidth-1:0];
            if (pos_q == '0) begin
              state_d = StIdle;
            end else begin
              pos_d = pos_q - PosWidth'(1);
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      sign_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sign_pend_q <= sign_pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    pos_q  <= pos_d;
    len_q  <= len_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  // output beat, text length is held for the whole run
  logic [LenWidth-1:0] out_len_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StEmit && out_free) begin
      out_len_q <= len_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign character_o   = char_q;
  assign text_length_o = out_len_q;
  assign is_last_o     = last_q;

endmodule

FILE: dv/tb.sv
// testbench for the signed integer to decimal text converter, self-checking with random pacing
`timescale 1ns / 1ps

module tb;
  import sitda_pkg::*;

  localparam int unsigned Radix       = 10;
  localparam int unsigned RandomItems = 310;
  localparam int unsigned CornerItems = 22;
  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned DrainCycles = 20;

  // one expected output beat
  typedef struct packed {
    logic [CharWidth-1:0] ch;
    logic [LenWidth-1:0]  len;
    logic                 last;
  } text_beat_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic signed [ValueWidth-1:0] value_i     = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [CharWidth-1:0]         character_o;
  logic [LenWidth-1:0]          text_length_o;
  logic                         is_last_o;

  // extremes, sign edges, digit-count edges
  logic signed [ValueWidth-1:0] corner_values [CornerItems] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99, -32'sd100,
    32'sd12345, 32'sd2147483647, 32'h8000_0000, -32'sd2147483647, 32'sd1000000000,
    -32'sd1000000000, 32'sd999999999, -32'sd999999999, 32'sd1234567890,
    -32'sd123456789, 32'sd100000, 32'sd7, -32'sd5
  };

  logic signed [ValueWidth-1:0] value_q [$];
  text_beat_t                   text_q [$];
  int unsigned                  total_values = 0;
  int unsigned                  taken_values = 0;
  int unsigned                  errors       = 0;
  int unsigned                  cycles       = 0;
  logic                         in_beat      = 1'b0;
  int unsigned                  in_gap       = 0;
  int unsigned                  out_hold     = 0;
  bit                           in_calm      = 1'b0;
  bit                           out_calm     = 1'b0;

  signed_int_to_decimal_ascii dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .character_o   (character_o),
    .text_length_o (text_length_o),
    .is_last_o     (is_last_o)
  );

  always #5 clk_i = ~clk_i;

  // idle length: mostly none or short, a few long, none at all in calm stretches
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // queue the characters of one value, sign first, then digits from the top
  function automatic void spell_value(input logic signed [ValueWidth-1:0] v);
    logic [ValueWidth-1:0] mag;
    logic [3:0]            digit [MaxDigits];
    logic [LenWidth-1:0]   len;
    logic                  neg;
    int unsigned           nd;
    int unsigned           total;
    int unsigned           pos;
    int                    i;
    neg = v[ValueWidth-1];
    mag = neg ? -$unsigned(v) : $unsigned(v);
    nd = 0;
    do begin
      digit[nd] = 4'(mag % Radix);
      nd++;
      mag = mag / Radix;
    end while (mag != 0);
    total = nd + (neg ? 1 : 0);
    len = LenWidth'(total);
    pos = 0;
    if (neg) begin
      pos++;
      text_q.push_back(text_beat_t'{CharMinus, len, pos == total});
    end
    for (i = nd; i > 0; i--) begin
      pos++;
      text_q.push_back(text_beat_t'{CharZero + CharWidth'(digit[i-1]), len, pos == total});
    end
  endfunction

  // run guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin : monitor
    text_beat_t want;
    in_beat <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      spell_value(value_i);
      taken_values++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (text_q.size() == 0) begin
        $error("tb: character beat 0x%02h with nothing expected", character_o);
        errors++;
      end else begin
        want = text_q.pop_front();
        if (character_o !== want.ch) begin
          $error("tb: character expected 0x%02h got 0x%02h", want.ch, character_o);
          errors++;
        end
        if (text_length_o !== want.len) begin
          $error("tb: text_length expected %0d got %0d", want.len, text_length_o);
          errors++;
        end
        if (is_last_o !== want.last) begin
          $error("tb: is_last expected %0b got %0b", want.last, is_last_o);
          errors++;
        end
      end
    end
  end

  // driver: input beats from the pending queue, random output stalls
  always @(negedge clk_i) begin : driver
    if (rst_ni) begin
      // hold a stalled beat, otherwise move on
      if (!in_valid_i || in_beat) begin
        if (in_gap != 0) begin
          in_valid_i <= 1'b0;
          in_gap--;
        end else if (value_q.size() != 0) begin
          in_valid_i <= 1'b1;
          value_i    <= value_q.pop_front();
          if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
          in_gap = pick_gap(in_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      // receiver back-pressure
      if (out_hold != 0) begin
        out_stall_i <= 1'b1;
        out_hold--;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 29) == 0) out_calm = !out_calm;
        if ($urandom_range(0, 3) == 0) out_hold = pick_gap(out_calm);
      end
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned                  n;
    int unsigned                  ndig;
    int unsigned                  mag;
    longint unsigned              base;
    logic signed [ValueWidth-1:0] v;
    for (n = 0; n < CornerItems; n++) value_q.push_back(corner_values[n]);
    for (n = 0; n < RandomItems; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        v = $urandom;
      end else begin
        // pick a digit count first so short and long strings are both common
        ndig = $urandom_range(1, MaxDigits);
        base = 1;
        repeat (ndig - 1) base = base * Radix;
        if (ndig == MaxDigits) mag = 1000000000 + $urandom_range(0, 1147483647);
        else mag = 32'(base) + $urandom_range(0, 32'(9 * base - 1));
        v = $urandom_range(0, 1) ? -mag : mag;
      end
      value_q.push_back(v);
    end
    total_values = value_q.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (taken_values != total_values || text_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
